// ----- hdl/fseu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fseu_pkg
// Shared constants, command and error codes, and word types for the Forth
// stack execution unit.
// ----------------------------------------------------------------------------
package fseu_pkg;

	localparam int DATA_DEPTH   = 64;
	localparam int RETURN_DEPTH = 32;
	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int RAW = $clog2(RETURN_DEPTH);
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int RCW = $clog2(RETURN_DEPTH + 1);

	localparam logic [31:0] TRUE_VALUE = 32'hFFFF_FFFF;
	localparam int OUTER_OFFSET = 3;

	localparam logic [5:0] CMD_LIT    = 6'd0;
	localparam logic [5:0] CMD_ADD    = 6'd1;
	localparam logic [5:0] CMD_SUB    = 6'd2;
	localparam logic [5:0] CMD_MUL    = 6'd3;
	localparam logic [5:0] CMD_DIV    = 6'd4;
	localparam logic [5:0] CMD_MOD    = 6'd5;
	localparam logic [5:0] CMD_AND    = 6'd6;
	localparam logic [5:0] CMD_OR     = 6'd7;
	localparam logic [5:0] CMD_XOR    = 6'd8;
	localparam logic [5:0] CMD_INVERT = 6'd9;
	localparam logic [5:0] CMD_LSHIFT = 6'd10;
	localparam logic [5:0] CMD_RSHIFT = 6'd11;
	localparam logic [5:0] CMD_EQ     = 6'd12;
	localparam logic [5:0] CMD_LT     = 6'd13;
	localparam logic [5:0] CMD_GT     = 6'd14;
	localparam logic [5:0] CMD_ZEQ    = 6'd15;
	localparam logic [5:0] CMD_DUP    = 6'd16;
	localparam logic [5:0] CMD_DROP   = 6'd17;
	localparam logic [5:0] CMD_SWAP   = 6'd18;
	localparam logic [5:0] CMD_OVER   = 6'd19;
	localparam logic [5:0] CMD_ROT    = 6'd20;
	localparam logic [5:0] CMD_DEPTH  = 6'd21;
	localparam logic [5:0] CMD_PICK   = 6'd22;
	localparam logic [5:0] CMD_TOR    = 6'd23;
	localparam logic [5:0] CMD_RFROM  = 6'd24;
	localparam logic [5:0] CMD_RFETCH = 6'd25;
	localparam logic [5:0] CMD_DO     = 6'd26;
	localparam logic [5:0] CMD_LOOP   = 6'd27;
	localparam logic [5:0] CMD_PLOOP  = 6'd28;
	localparam logic [5:0] CMD_I      = 6'd29;
	localparam logic [5:0] CMD_J      = 6'd30;
	localparam logic [5:0] CMD_UNLOOP = 6'd31;
	localparam logic [5:0] CMD_ZBRAN  = 6'd32;
	localparam logic [5:0] CMD_PRINT  = 6'd33;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_DUNDER  = 3'd1;
	localparam logic [2:0] ERR_RUNDER  = 3'd2;
	localparam logic [2:0] ERR_DIVZERO = 3'd3;
	localparam logic [2:0] ERR_PICK    = 3'd4;
	localparam logic [2:0] ERR_DOVER   = 3'd5;
	localparam logic [2:0] ERR_ROVER   = 3'd6;

	typedef struct packed {
		logic [5:0]         cmd;
		logic signed [31:0] literal;
	} fseu_in_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic               top_valid;
		logic [6:0]         data_depth;
		logic [5:0]         return_depth;
		logic               branch_taken;
		logic signed [31:0] printed_value;
		logic               printed_valid;
		logic [2:0]         error;
	} fseu_out_t;

	typedef struct packed {
		logic       accept;
		logic       cap_ops;
		logic       rd_third;
		logic       plan_ld;
		logic       div_start;
		logic       wr_en;
		logic [1:0] wr_idx;
	} fseu_ctl_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} fseu_sts_t;

endpackage

// ----- hdl/fseu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fseu_div
// Signed 32-bit restoring divider, one quotient bit per cycle. Quotient
// truncates toward zero, remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module fseu_div import fseu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dmag_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dmag_q};
	assign ge      = ~diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
			dmag_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q  <= '0;
			qneg_q <= dividend[31] ^ divisor[31];
			rneg_q <= dividend[31];
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (32'd0 - quo_q) : quo_q;
	assign remainder = rneg_q ? (32'd0 - rem_q) : rem_q;

endmodule

// ----- hdl/fseu_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fseu_dp
// Datapath: both stack memories, operand and count registers, primitive
// decode into a write plan, divider, and result word.
// ----------------------------------------------------------------------------
module fseu_dp import fseu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fseu_in_t  item,
	input  fseu_ctl_t ctl,
	output fseu_sts_t sts,
	output fseu_out_t result
);

	typedef struct packed {
		logic [2:0]               err;
		logic                     branch;
		logic [31:0]              pv;
		logic                     pvalid;
		logic [2:0]               dw_en;
		logic [2:0][DAW-1:0]      dw_addr;
		logic [2:0][31:0]         dw_data;
		logic [1:0]               rw_en;
		logic [1:0][RAW-1:0]      rw_addr;
		logic [1:0][31:0]         rw_data;
		logic                     is_div;
		logic [DCW-1:0]           ndc;
		logic [RCW-1:0]           nrc;
	} plan_t;

	logic [31:0]    dmem_q [DATA_DEPTH];
	logic [31:0]    rmem_q [RETURN_DEPTH];
	logic [5:0]     cmd_q;
	logic [31:0]    lit_q;
	logic [DCW-1:0] dc_q;
	logic [RCW-1:0] rc_q;
	logic [31:0]    b_q, a_q, r1_q, r2_q;
	logic [31:0]    rda_q, rdb_q, rra_q, rrb_q;
	plan_t          plan_q;
	plan_t          p;

	logic [DCW-1:0] dc_m1, dc_m2, dc_m3;
	logic [RCW-1:0] rc_m1, rc_m2, rc_m3;
	logic [DAW-1:0] d_addr_a, pick_addr;
	logic [RAW-1:0] r_addr_b;
	logic [31:0]    alu, step, idx;
	logic           dc_full, again;
	logic [RCW:0]   rc_p2;
	logic           div_done;
	logic [31:0]    quo, rem;

	assign dc_m1 = dc_q - DCW'(1);
	assign dc_m2 = dc_q - DCW'(2);
	assign dc_m3 = dc_q - DCW'(3);
	assign rc_m1 = rc_q - RCW'(1);
	assign rc_m2 = rc_q - RCW'(2);
	assign rc_m3 = rc_q - RCW'(OUTER_OFFSET);
	assign pick_addr = dc_m2[DAW-1:0] - rda_q[DAW-1:0];
	assign d_addr_a  = ctl.rd_third ? ((cmd_q == CMD_PICK) ? pick_addr : dc_m3[DAW-1:0])
	                                : dc_m1[DAW-1:0];
	assign r_addr_b  = (item.cmd == CMD_J) ? rc_m3[RAW-1:0] : rc_m2[RAW-1:0];

	always_ff @(posedge clk) begin
		rda_q <= dmem_q[d_addr_a];
		rdb_q <= dmem_q[dc_m2[DAW-1:0]];
		rra_q <= rmem_q[rc_m1[RAW-1:0]];
		rrb_q <= rmem_q[r_addr_b];
		if (ctl.wr_en && plan_q.dw_en[ctl.wr_idx])
			dmem_q[plan_q.dw_addr[ctl.wr_idx]] <= plan_q.dw_data[ctl.wr_idx];
		if (ctl.wr_en && ctl.wr_idx != 2'd2 && plan_q.rw_en[ctl.wr_idx[0]])
			rmem_q[plan_q.rw_addr[ctl.wr_idx[0]]] <= plan_q.rw_data[ctl.wr_idx[0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= item.cmd;
			lit_q <= item.literal;
		end
		if (ctl.cap_ops) begin
			b_q  <= rda_q;
			a_q  <= rdb_q;
			r1_q <= rra_q;
			r2_q <= rrb_q;
		end
		if (ctl.plan_ld)
			plan_q <= p;
		else if (div_done)
			plan_q.dw_data[0] <= (cmd_q == CMD_DIV) ? quo : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
			rc_q <= '0;
		end else if (ctl.plan_ld) begin
			dc_q <= p.ndc;
			rc_q <= p.nrc;
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_ADD:    alu = a_q + b_q;
			CMD_SUB:    alu = a_q - b_q;
			CMD_MUL:    alu = a_q * b_q;
			CMD_AND:    alu = a_q & b_q;
			CMD_OR:     alu = a_q | b_q;
			CMD_XOR:    alu = a_q ^ b_q;
			CMD_LSHIFT: alu = (b_q >= 32'd32) ? 32'd0 : (a_q << b_q[4:0]);
			CMD_RSHIFT: alu = (b_q >= 32'd32) ? 32'd0 : (a_q >> b_q[4:0]);
			CMD_EQ:     alu = (a_q == b_q) ? TRUE_VALUE : 32'd0;
			CMD_LT:     alu = ($signed(a_q) < $signed(b_q)) ? TRUE_VALUE : 32'd0;
			CMD_GT:     alu = ($signed(a_q) > $signed(b_q)) ? TRUE_VALUE : 32'd0;
			default:    alu = 32'd0;
		endcase
	end

	assign step    = (cmd_q == CMD_PLOOP) ? b_q : 32'd1;
	assign idx     = r1_q + step;
	assign dc_full = dc_q >= DCW'(DATA_DEPTH);
	assign rc_p2   = {1'b0, rc_q} + (RCW+1)'(2);

	always_comb begin
		if (cmd_q == CMD_LOOP || $signed(step) > 0)
			again = $signed(idx) < $signed(r2_q);
		else if ($signed(step) < 0)
			again = $signed(idx) >= $signed(r2_q);
		else
			again = 1'b0;
	end

	always_comb begin
		p     = '0;
		p.ndc = dc_q;
		p.nrc = rc_q;
		unique case (cmd_q) inside
			CMD_LIT, CMD_DEPTH: begin
				if (dc_full) p.err = ERR_DOVER;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_q[DAW-1:0];
					p.dw_data[0] = (cmd_q == CMD_LIT) ? lit_q : 32'(dc_q);
					p.ndc        = dc_q + DCW'(1);
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR,
			CMD_LSHIFT, CMD_RSHIFT, CMD_EQ, CMD_LT, CMD_GT: begin
				if (dc_q < DCW'(2)) p.err = ERR_DUNDER;
				else if ((cmd_q == CMD_DIV || cmd_q == CMD_MOD) && b_q == 32'd0)
					p.err = ERR_DIVZERO;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_m2[DAW-1:0];
					p.dw_data[0] = alu;
					p.ndc        = dc_m1;
					p.is_div     = (cmd_q == CMD_DIV || cmd_q == CMD_MOD);
				end
			end
			CMD_INVERT, CMD_ZEQ: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_m1[DAW-1:0];
					p.dw_data[0] = (cmd_q == CMD_INVERT) ? ~b_q
					               : ((b_q == 32'd0) ? TRUE_VALUE : 32'd0);
				end
			end
			CMD_DUP, CMD_OVER: begin
				if (dc_q < ((cmd_q == CMD_DUP) ? DCW'(1) : DCW'(2))) p.err = ERR_DUNDER;
				else if (dc_full) p.err = ERR_DOVER;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_q[DAW-1:0];
					p.dw_data[0] = (cmd_q == CMD_DUP) ? b_q : a_q;
					p.ndc        = dc_q + DCW'(1);
				end
			end
			CMD_DROP: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else p.ndc = dc_m1;
			end
			CMD_SWAP: begin
				if (dc_q < DCW'(2)) p.err = ERR_DUNDER;
				else begin
					p.dw_en[1:0]  = 2'b11;
					p.dw_addr[0]  = dc_m2[DAW-1:0];
					p.dw_data[0]  = b_q;
					p.dw_addr[1]  = dc_m1[DAW-1:0];
					p.dw_data[1]  = a_q;
				end
			end
			CMD_ROT: begin
				if (dc_q < DCW'(3)) p.err = ERR_DUNDER;
				else begin
					p.dw_en       = 3'b111;
					p.dw_addr[0]  = dc_m3[DAW-1:0];
					p.dw_data[0]  = a_q;
					p.dw_addr[1]  = dc_m2[DAW-1:0];
					p.dw_data[1]  = b_q;
					p.dw_addr[2]  = dc_m1[DAW-1:0];
					p.dw_data[2]  = rda_q;
				end
			end
			CMD_PICK: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else if (b_q[31] || b_q >= 32'(dc_m1)) p.err = ERR_PICK;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_m1[DAW-1:0];
					p.dw_data[0] = rda_q;
				end
			end
			CMD_TOR: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else if (rc_q >= RCW'(RETURN_DEPTH)) p.err = ERR_ROVER;
				else begin
					p.rw_en[0]   = 1'b1;
					p.rw_addr[0] = rc_q[RAW-1:0];
					p.rw_data[0] = b_q;
					p.nrc        = rc_q + RCW'(1);
					p.ndc        = dc_m1;
				end
			end
			CMD_RFROM, CMD_RFETCH, CMD_I, CMD_J: begin
				if (rc_q < ((cmd_q == CMD_J) ? RCW'(OUTER_OFFSET) : RCW'(1)))
					p.err = ERR_RUNDER;
				else if (dc_full) p.err = ERR_DOVER;
				else begin
					p.dw_en[0]   = 1'b1;
					p.dw_addr[0] = dc_q[DAW-1:0];
					p.dw_data[0] = (cmd_q == CMD_J) ? r2_q : r1_q;
					p.ndc        = dc_q + DCW'(1);
					if (cmd_q == CMD_RFROM) p.nrc = rc_m1;
				end
			end
			CMD_DO: begin
				if (dc_q < DCW'(2)) p.err = ERR_DUNDER;
				else if (rc_p2 > (RCW+1)'(RETURN_DEPTH)) p.err = ERR_ROVER;
				else begin
					p.rw_en      = 2'b11;
					p.rw_addr[0] = rc_q[RAW-1:0];
					p.rw_data[0] = a_q;
					p.rw_addr[1] = rc_q[RAW-1:0] + RAW'(1);
					p.rw_data[1] = b_q;
					p.nrc        = rc_p2[RCW-1:0];
					p.ndc        = dc_m2;
				end
			end
			CMD_LOOP, CMD_PLOOP: begin
				if (cmd_q == CMD_PLOOP && dc_q == '0) p.err = ERR_DUNDER;
				else if (rc_q < RCW'(2)) p.err = ERR_RUNDER;
				else begin
					if (cmd_q == CMD_PLOOP) p.ndc = dc_m1;
					if (again) begin
						p.rw_en[0]   = 1'b1;
						p.rw_addr[0] = rc_m1[RAW-1:0];
						p.rw_data[0] = idx;
						p.branch     = 1'b1;
					end else begin
						p.nrc = rc_m2;
					end
				end
			end
			CMD_UNLOOP: begin
				if (rc_q < RCW'(2)) p.err = ERR_RUNDER;
				else p.nrc = rc_m2;
			end
			CMD_ZBRAN: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else begin
					p.ndc    = dc_m1;
					p.branch = (b_q == 32'd0);
				end
			end
			CMD_PRINT: begin
				if (dc_q == '0) p.err = ERR_DUNDER;
				else begin
					p.ndc    = dc_m1;
					p.pv     = b_q;
					p.pvalid = 1'b1;
				end
			end
			default: ;
		endcase
		if (p.err != ERR_NONE) begin
			p.ndc    = '0;
			p.nrc    = '0;
			p.branch = 1'b0;
			p.pv     = '0;
			p.pvalid = 1'b0;
			p.dw_en  = '0;
			p.rw_en  = '0;
			p.is_div = 1'b0;
		end
	end

	fseu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign sts.need_div = p.is_div;
	assign sts.div_done = div_done;

	assign result.top_value     = (dc_q != '0) ? rda_q : 32'd0;
	assign result.top_valid     = (dc_q != '0);
	assign result.data_depth    = 7'(dc_q);
	assign result.return_depth  = 6'(rc_q);
	assign result.branch_taken  = plan_q.branch;
	assign result.printed_value = plan_q.pv;
	assign result.printed_valid = plan_q.pvalid;
	assign result.error         = plan_q.err;

endmodule

// ----- hdl/fseu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fseu_ctrl
// Sequencer: operand fetch, decode, divide wait, stack write-back, top
// read, result strobe.
// ----------------------------------------------------------------------------
module fseu_ctrl import fseu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  fseu_sts_t sts,
	output fseu_ctl_t ctl,
	output logic      busy,
	output logic      done
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_EXEC, S_DIV, S_WR0, S_WR1, S_WR2, S_TOP, S_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					state_q <= S_LOAD;
					busy_q  <= 1'b1;
				end
				S_LOAD: state_q <= S_EXEC;
				S_EXEC: state_q <= sts.need_div ? S_DIV : S_WR0;
				S_DIV:  if (sts.div_done) state_q <= S_WR0;
				S_WR0:  state_q <= S_WR1;
				S_WR1:  state_q <= S_WR2;
				S_WR2:  state_q <= S_TOP;
				S_TOP: begin
					state_q <= S_EMIT;
					done_q  <= 1'b1;
				end
				S_EMIT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.accept    = accept;
		ctl.cap_ops   = (state_q == S_LOAD);
		ctl.rd_third  = (state_q == S_LOAD);
		ctl.plan_ld   = (state_q == S_EXEC);
		ctl.div_start = (state_q == S_EXEC) && sts.need_div;
		ctl.wr_en     = (state_q == S_WR0) || (state_q == S_WR1) || (state_q == S_WR2);
		ctl.wr_idx    = (state_q == S_WR2) ? 2'd2 : ((state_q == S_WR1) ? 2'd1 : 2'd0);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- hdl/forth_stack_execution_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_stack_execution_unit
// Executes one Forth primitive per word on a data stack and a return stack.
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  command   start & !busy      item   (cmd, literal)
//  result    done, one cycle    result (top, depths, branch, print, error)
//
//  done is high in S_EMIT, after S_LOAD, S_EXEC, S_WR0 to S_WR2 and S_TOP;
//  / and mod also wait in S_DIV for the one-bit-per-cycle divider. The
//  sequencer fetches operands from the stack memories, writes back in
//  S_WR0, S_WR1 and S_WR2 and reads the new top. busy is low from the cycle after
//  done, so a new word is accepted only once the last one has finished.
//  Reset empties both stacks at once. The receiver cannot stall.
// ----------------------------------------------------------------------------
module forth_stack_execution_unit import fseu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  fseu_in_t  item,
	output logic      done,
	output fseu_out_t result
);

	fseu_ctl_t ctl;
	fseu_sts_t sts;

	fseu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	fseu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a busy word");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised on accept");

	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error != ERR_NONE) |->
		(result.data_depth == 7'd0 && result.return_depth == 6'd0))
		else $error("stacks not cleared on error");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.top_valid == (result.data_depth != 7'd0)))
		else $error("top_valid disagrees with depth");

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.data_depth <= 7'(DATA_DEPTH)))
		else $error("data depth beyond capacity");

endmodule

// ----- bench/forth_stack_execution_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_stack_execution_unit_tb
// Self-checking bench for the Forth stack execution unit. A behavioral
// stack machine in the bench predicts every result word; directed tests hit
// selected primitives, the error paths and the stack limits, then random
// programs of loops, arithmetic and shuffles run, first with random idle gaps.
// ----------------------------------------------------------------------------
module forth_stack_execution_unit_tb;
	import fseu_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	fseu_in_t  item = '0;
	logic      done;
	fseu_out_t result;

	forth_stack_execution_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] dstk [DATA_DEPTH];
	logic [31:0] rstk [RETURN_DEPTH];
	int unsigned dcnt = 0, rcnt = 0;
	fseu_out_t   pending_results[$];
	int          fail_count = 0;
	int          word_count = 0;
	int          result_count = 0;
	int          error_count = 0;
	bit          gaps_on = 1'b1;

	function automatic bit slt(logic [31:0] x, logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	function automatic fseu_out_t execute_word(logic [5:0] cmd, logic [31:0] lit);
		fseu_out_t o;
		int unsigned dc, rc;
		logic [2:0] err;
		logic [31:0] a, b, r, stp, idx;
		bit br, pvld, again;
		logic [31:0] pv;
		longint n;
		dc = dcnt; rc = rcnt; err = ERR_NONE; br = 0; pvld = 0; pv = '0; r = '0;
		a = '0; b = '0;
		if (dc >= 1) b = dstk[dc-1];
		if (dc >= 2) a = dstk[dc-2];
		case (cmd)
			CMD_LIT, CMD_DEPTH: begin
				if (dc >= DATA_DEPTH) err = ERR_DOVER;
				else begin
					dstk[dc] = (cmd == CMD_LIT) ? lit : 32'(dc);
					dc++;
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR,
			CMD_LSHIFT, CMD_RSHIFT, CMD_EQ, CMD_LT, CMD_GT: begin
				if (dc < 2) err = ERR_DUNDER;
				else begin
					case (cmd)
						CMD_ADD: r = a + b;
						CMD_SUB: r = a - b;
						CMD_MUL: r = a * b;
						CMD_DIV, CMD_MOD: begin
							if (b == 0) err = ERR_DIVZERO;
							else if (a == 32'h8000_0000 && b == TRUE_VALUE)
								r = (cmd == CMD_DIV) ? a : '0;
							else if (cmd == CMD_DIV) r = $signed(a) / $signed(b);
							else r = $signed(a) % $signed(b);
						end
						CMD_AND: r = a & b;
						CMD_OR:  r = a | b;
						CMD_XOR: r = a ^ b;
						CMD_LSHIFT: r = (b >= 32) ? '0 : a << b[4:0];
						CMD_RSHIFT: r = (b >= 32) ? '0 : a >> b[4:0];
						CMD_EQ: r = (a == b) ? TRUE_VALUE : '0;
						CMD_LT: r = slt(a, b) ? TRUE_VALUE : '0;
						default: r = slt(b, a) ? TRUE_VALUE : '0;
					endcase
					if (err == ERR_NONE) begin
						dc--;
						dstk[dc-1] = r;
					end
				end
			end
			CMD_INVERT, CMD_ZEQ: begin
				if (dc < 1) err = ERR_DUNDER;
				else dstk[dc-1] = (cmd == CMD_INVERT) ? ~b : ((b == 0) ? TRUE_VALUE : '0);
			end
			CMD_DUP, CMD_OVER: begin
				if (dc < ((cmd == CMD_DUP) ? 1 : 2)) err = ERR_DUNDER;
				else if (dc >= DATA_DEPTH) err = ERR_DOVER;
				else begin
					dstk[dc] = (cmd == CMD_DUP) ? b : a;
					dc++;
				end
			end
			CMD_DROP: if (dc < 1) err = ERR_DUNDER; else dc--;
			CMD_SWAP: begin
				if (dc < 2) err = ERR_DUNDER;
				else begin
					dstk[dc-2] = b;
					dstk[dc-1] = a;
				end
			end
			CMD_ROT: begin
				if (dc < 3) err = ERR_DUNDER;
				else begin
					r = dstk[dc-3];
					dstk[dc-3] = a;
					dstk[dc-2] = b;
					dstk[dc-1] = r;
				end
			end
			CMD_PICK: begin
				if (dc < 1) err = ERR_DUNDER;
				else begin
					n = $signed(b);
					if (n < 0 || n >= longint'(dc - 1)) err = ERR_PICK;
					else dstk[dc-1] = dstk[dc-2-n];
				end
			end
			CMD_TOR: begin
				if (dc < 1) err = ERR_DUNDER;
				else if (rc >= RETURN_DEPTH) err = ERR_ROVER;
				else begin
					rstk[rc] = b;
					rc++;
					dc--;
				end
			end
			CMD_RFROM, CMD_RFETCH, CMD_I, CMD_J: begin
				if (rc < ((cmd == CMD_J) ? OUTER_OFFSET : 1)) err = ERR_RUNDER;
				else if (dc >= DATA_DEPTH) err = ERR_DOVER;
				else begin
					dstk[dc] = (cmd == CMD_J) ? rstk[rc-OUTER_OFFSET] : rstk[rc-1];
					dc++;
					if (cmd == CMD_RFROM) rc--;
				end
			end
			CMD_DO: begin
				if (dc < 2) err = ERR_DUNDER;
				else if (rc + 2 > RETURN_DEPTH) err = ERR_ROVER;
				else begin
					rstk[rc] = a;
					rstk[rc+1] = b;
					rc += 2;
					dc -= 2;
				end
			end
			CMD_LOOP, CMD_PLOOP: begin
				if (cmd == CMD_PLOOP && dc < 1) err = ERR_DUNDER;
				else if (rc < 2) err = ERR_RUNDER;
				else begin
					stp = 32'd1;
					if (cmd == CMD_PLOOP) begin
						stp = b;
						dc--;
					end
					idx = rstk[rc-1] + stp;
					if (cmd == CMD_LOOP || $signed(stp) > 0) again = slt(idx, rstk[rc-2]);
					else if ($signed(stp) < 0) again = !slt(idx, rstk[rc-2]);
					else again = 0;
					if (again) begin
						rstk[rc-1] = idx;
						br = 1;
					end else rc -= 2;
				end
			end
			CMD_UNLOOP: if (rc < 2) err = ERR_RUNDER; else rc -= 2;
			CMD_ZBRAN: begin
				if (dc < 1) err = ERR_DUNDER;
				else begin
					dc--;
					br = (b == 0);
				end
			end
			CMD_PRINT: begin
				if (dc < 1) err = ERR_DUNDER;
				else begin
					dc--;
					pv = b;
					pvld = 1;
				end
			end
			default: ;
		endcase
		if (err != ERR_NONE) begin
			dc = 0; rc = 0; br = 0; pv = '0; pvld = 0;
		end
		dcnt = dc;
		rcnt = rc;
		o.top_value     = (dc > 0) ? dstk[dc-1] : '0;
		o.top_valid     = (dc > 0);
		o.data_depth    = 7'(dc);
		o.return_depth  = 6'(rc);
		o.branch_taken  = br;
		o.printed_value = pv;
		o.printed_valid = pvld;
		o.error         = err;
		return o;
	endfunction

	task automatic send_word(logic [5:0] cmd, logic [31:0] lit = '0);
		int gap;
		gap = 1;
		if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
		repeat (gap) @(negedge clk);
		start <= 1'b1;
		item.cmd <= cmd;
		item.literal <= lit;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results = {pending_results, execute_word(cmd, lit)};
		word_count++;
		@(negedge clk);
		start <= 1'b0;
		item.literal <= $urandom;
	endtask

	always @(posedge clk) begin
		fseu_out_t exp_r;
		if (done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: got %h", $time, result);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.error != ERR_NONE) error_count++;
				if (result !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
					if (result.top_value !== exp_r.top_value)
						$display("%0t:  top_value expected %h actual %h", $time,
							exp_r.top_value, result.top_value);
					if (result.error !== exp_r.error)
						$display("%0t:  error expected %0d actual %0d", $time,
							exp_r.error, result.error);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return '0;
			4: return 32'd1;
			5: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_arith_edges();
		send_word(CMD_LIT, 32'h8000_0000);
		send_word(CMD_LIT, 32'hFFFF_FFFF);
		send_word(CMD_DIV);
		send_word(CMD_LIT, 32'hFFFF_FFFF);
		send_word(CMD_MOD);
		send_word(CMD_LIT, 32'h7FFF_FFFF);
		send_word(CMD_LIT, 32'd33);
		send_word(CMD_LSHIFT);
		send_word(CMD_LIT, 32'hFFFF_FFFF);
		send_word(CMD_LIT, 32'd31);
		send_word(CMD_RSHIFT);
		send_word(CMD_LIT, 32'd0);
		send_word(CMD_DIV);
		send_word(CMD_ADD);
		send_word(CMD_PRINT);
		send_word(CMD_UNLOOP);
		send_word(CMD_LIT, 32'd5);
		send_word(CMD_LIT, 32'd7);
		send_word(CMD_PICK);
		send_word(CMD_LIT, 32'd0);
		send_word(CMD_ZBRAN);
		send_word(CMD_J);
		send_word(6'd63);
	endtask

	task automatic test_stack_limits();
		repeat (DATA_DEPTH) send_word(CMD_DEPTH);
		send_word(CMD_DUP);
		repeat (RETURN_DEPTH + 1) begin
			send_word(CMD_LIT, $urandom);
			send_word(CMD_TOR);
		end
		repeat (DATA_DEPTH - 1) send_word(CMD_LIT, $urandom);
		send_word(CMD_I);
		send_word(CMD_RFETCH);
	endtask

	task automatic random_loop();
		int body;
		send_word(CMD_LIT, $urandom_range(0, 8) - 4);
		send_word(CMD_LIT, $urandom_range(0, 8) - 4);
		send_word(CMD_DO);
		repeat ($urandom_range(1, 6)) begin
			body = $urandom_range(0, 3);
			if (body == 0) send_word(CMD_I);
			else if (body == 1) send_word(CMD_J);
			else if (body == 2) send_word(CMD_RFETCH);
			else send_word(CMD_PRINT);
			if ($urandom_range(0, 1)) begin
				send_word(CMD_LIT, $urandom_range(0, 6) - 3);
				send_word(CMD_PLOOP);
			end else send_word(CMD_LOOP);
		end
		if ($urandom_range(0, 2) == 0) send_word(CMD_UNLOOP);
	endtask

	task automatic test_random_programs(int n);
		int k;
		while (word_count < n) begin
			k = $urandom_range(0, 9);
			if (k < 3) random_loop();
			else if (k < 6) begin
				send_word(CMD_LIT, edge_value());
				send_word(CMD_LIT, edge_value());
				send_word(6'($urandom_range(CMD_ADD, CMD_GT)));
			end else if (k < 9) begin
				if (dcnt < 3) send_word(CMD_LIT, edge_value());
				send_word(6'($urandom_range(CMD_INVERT, CMD_PRINT)), edge_value());
			end else send_word(6'($urandom_range(0, 63)), $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_arith_edges();
		test_stack_limits();
		test_random_programs(900);
		gaps_on = 1'b0;
		test_random_programs(1100);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Ran %0d words, %0d results checked, %0d with stack errors.",
			word_count, result_count, error_count);
		if (fail_count == 0 && pending_results.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
